// ----- rtl/core/assert_macros.svh -----
// concurrent assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

// ----- rtl/core/mbrm_pkg.sv -----
package mbrm_pkg;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_WAIT = 1'b1
  } phase_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic OUT_TX       = 1'b0;
  localparam logic OUT_COMPLETE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;
  localparam logic [1:0] ST_HDR_ERR = 2'd3;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_REG_ADDR   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  RESP_BYTE_COUNT   = 8'h02;

  localparam logic [7:0]  RST_SLAVE_ADDR = 8'd1;
  localparam logic [15:0] RST_REG_ADDR   = 16'd5;
  localparam logic [15:0] RST_TIMEOUT    = 16'd1000;

  localparam logic [2:0] TX_CRC_LO_IDX = 3'd6;
  localparam logic [2:0] TX_LAST_IDX   = 3'd7;
  localparam logic [2:0] RX_CRC_LO_IDX = 3'd5;
  localparam logic [2:0] RX_CRC_HI_IDX = 3'd6;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/modbus_read_register_master.sv -----
// path: a completion passes the input register and then the result register; each request
//   byte passes the input register, the transmit sequencer and then the output register
// flow: one input item per cycle while in_stall is low; a start drives eight request bytes
//   in order, and the next item waits in the input register until the last byte is loaded
// reset (rst_n low, synchronous): idle, channels empty, registers at defaults
`include "assert_macros.svh"

module modbus_read_register_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [15:0] out_read_value
);

  localparam logic [2:0] RX_FOLD_END = mbrm_pkg::RX_CRC_LO_IDX;

  logic [7:0]  slave_addr_r;
  logic [15:0] reg_addr_r;
  logic [15:0] timeout_r;

  logic        in_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  rx_byte_r;

  mbrm_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  rx_count_r, rx_count_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [15:0] data_word_r, data_word_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic        tx_busy_r, tx_busy_nxt;
  logic [2:0]  tx_idx_r, tx_idx_nxt;
  logic [15:0] tx_crc_r, tx_crc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_tx_byte_r, out_tx_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [15:0] out_read_value_r, out_read_value_nxt;

  logic        out_free;
  logic        is_wait;
  logic        byte_done;
  logic        tick_done;
  logic        has_result;
  logic        proc_go;
  logic        cmp_load;
  logic        tx_load;
  logic [15:0] elapsed_inc;
  logic [15:0] crc_got;
  logic [7:0]  tx_data;

  assign out_free  = !out_valid_r || !out_stall;
  assign is_wait   = (phase_r == mbrm_pkg::PH_WAIT);
  assign elapsed_inc = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;
  assign byte_done = is_wait && (kind_r == mbrm_pkg::KIND_BYTE)
                     && (rx_count_r >= mbrm_pkg::RX_CRC_HI_IDX);
  assign tick_done = is_wait && (kind_r == mbrm_pkg::KIND_TICK)
                     && (elapsed_inc >= timeout_r);
  assign has_result = byte_done || tick_done;
  assign proc_go  = in_valid_r && !tx_busy_r && (!has_result || out_free);
  assign cmp_load = proc_go && has_result;
  assign tx_load  = tx_busy_r && out_free;
  assign in_stall = in_valid_r && !proc_go;
  assign crc_got  = {rx_byte_r, crc_lo_r};

  // request byte currently at the head of the transmit sequence
  always_comb begin
    case (tx_idx_r)
      3'd0:    tx_data = slave_addr_r;
      3'd1:    tx_data = mbrm_pkg::FUNC_READ_HOLDING;
      3'd2:    tx_data = reg_addr_r[15:8];
      3'd3:    tx_data = reg_addr_r[7:0];
      3'd4:    tx_data = 8'h00;
      3'd5:    tx_data = 8'h01;
      3'd6:    tx_data = tx_crc_r[7:0];
      default: tx_data = tx_crc_r[15:8];
    endcase
  end

  // phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (proc_go) begin
      case (kind_r)
        mbrm_pkg::KIND_START: phase_nxt = mbrm_pkg::PH_WAIT;
        mbrm_pkg::KIND_BYTE: begin
          if (byte_done) phase_nxt = mbrm_pkg::PH_IDLE;
        end
        mbrm_pkg::KIND_TICK: begin
          if (tick_done) phase_nxt = mbrm_pkg::PH_IDLE;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // receive datapath, transmit sequencer and result register
  always_comb begin
    rx_count_nxt  = rx_count_r;
    crc_acc_nxt   = crc_acc_r;
    hdr_good_nxt  = hdr_good_r;
    data_word_nxt = data_word_r;
    crc_lo_nxt    = crc_lo_r;
    elapsed_nxt   = elapsed_r;
    tx_busy_nxt   = tx_busy_r;
    tx_idx_nxt    = tx_idx_r;
    tx_crc_nxt    = tx_crc_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_kind_nxt       = out_kind_r;
    out_tx_byte_nxt    = out_tx_byte_r;
    out_last_nxt       = out_last_r;
    out_status_nxt     = out_status_r;
    out_read_value_nxt = out_read_value_r;

    if (tx_load) begin
      out_valid_nxt      = 1'b1;
      out_kind_nxt       = mbrm_pkg::OUT_TX;
      out_tx_byte_nxt    = tx_data;
      out_last_nxt       = (tx_idx_r == mbrm_pkg::TX_LAST_IDX);
      out_status_nxt     = mbrm_pkg::ST_OK;
      out_read_value_nxt = 16'h0000;
      tx_idx_nxt         = tx_idx_r + 3'd1;
      if (tx_idx_r < mbrm_pkg::TX_CRC_LO_IDX) begin
        tx_crc_nxt = mbrm_pkg::crc_fold(tx_crc_r, tx_data);
      end
      if (tx_idx_r == mbrm_pkg::TX_LAST_IDX) begin
        tx_busy_nxt = 1'b0;
      end
    end

    if (proc_go) begin
      case (kind_r)
        mbrm_pkg::KIND_START: begin
          rx_count_nxt  = 3'd0;
          crc_acc_nxt   = mbrm_pkg::CRC_INIT;
          hdr_good_nxt  = 1'b1;
          data_word_nxt = 16'h0000;
          crc_lo_nxt    = 8'h00;
          elapsed_nxt   = 16'h0000;
          tx_busy_nxt   = 1'b1;
          tx_idx_nxt    = 3'd0;
          tx_crc_nxt    = mbrm_pkg::CRC_INIT;
        end
        mbrm_pkg::KIND_BYTE: begin
          if (is_wait) begin
            if (rx_count_r < RX_FOLD_END) begin
              crc_acc_nxt = mbrm_pkg::crc_fold(crc_acc_r, rx_byte_r);
            end
            case (rx_count_r)
              3'd0: begin
                if (rx_byte_r != slave_addr_r) hdr_good_nxt = 1'b0;
              end
              3'd1: begin
                if (rx_byte_r != mbrm_pkg::FUNC_READ_HOLDING) hdr_good_nxt = 1'b0;
              end
              3'd2: begin
                if (rx_byte_r != mbrm_pkg::RESP_BYTE_COUNT) hdr_good_nxt = 1'b0;
              end
              3'd3:    data_word_nxt = {rx_byte_r, 8'h00};
              3'd4:    data_word_nxt = {data_word_r[15:8], rx_byte_r};
              3'd5:    crc_lo_nxt = rx_byte_r;
              default: crc_lo_nxt = crc_lo_r;
            endcase
            if (byte_done) begin
              rx_count_nxt       = 3'd0;
              out_valid_nxt      = 1'b1;
              out_kind_nxt       = mbrm_pkg::OUT_COMPLETE;
              out_tx_byte_nxt    = 8'h00;
              out_last_nxt       = 1'b0;
              out_read_value_nxt = 16'h0000;
              if (crc_got != crc_acc_r) begin
                out_status_nxt = mbrm_pkg::ST_CRC_ERR;
              end else if (!hdr_good_r) begin
                out_status_nxt = mbrm_pkg::ST_HDR_ERR;
              end else begin
                out_status_nxt     = mbrm_pkg::ST_OK;
                out_read_value_nxt = data_word_r;
              end
            end else begin
              rx_count_nxt = rx_count_r + 3'd1;
            end
          end
        end
        mbrm_pkg::KIND_TICK: begin
          if (is_wait) begin
            elapsed_nxt = elapsed_inc;
            if (tick_done) begin
              rx_count_nxt       = 3'd0;
              out_valid_nxt      = 1'b1;
              out_kind_nxt       = mbrm_pkg::OUT_COMPLETE;
              out_tx_byte_nxt    = 8'h00;
              out_last_nxt       = 1'b0;
              out_status_nxt     = mbrm_pkg::ST_TIMEOUT;
              out_read_value_nxt = 16'h0000;
            end
          end
        end
        default: elapsed_nxt = elapsed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mbrm_pkg::RST_SLAVE_ADDR;
      reg_addr_r   <= mbrm_pkg::RST_REG_ADDR;
      timeout_r    <= mbrm_pkg::RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        mbrm_pkg::CFG_SLAVE_ADDR: slave_addr_r <= cfg_wdata[7:0];
        mbrm_pkg::CFG_REG_ADDR:   reg_addr_r   <= cfg_wdata;
        mbrm_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default:                  timeout_r    <= timeout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      phase_r     <= mbrm_pkg::PH_IDLE;
      rx_count_r  <= 3'd0;
      crc_acc_r   <= mbrm_pkg::CRC_INIT;
      hdr_good_r  <= 1'b1;
      data_word_r <= 16'h0000;
      crc_lo_r    <= 8'h00;
      elapsed_r   <= 16'h0000;
      tx_busy_r   <= 1'b0;
      tx_idx_r    <= 3'd0;
      tx_crc_r    <= mbrm_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      phase_r     <= phase_nxt;
      rx_count_r  <= rx_count_nxt;
      crc_acc_r   <= crc_acc_nxt;
      hdr_good_r  <= hdr_good_nxt;
      data_word_r <= data_word_nxt;
      crc_lo_r    <= crc_lo_nxt;
      elapsed_r   <= elapsed_nxt;
      tx_busy_r   <= tx_busy_nxt;
      tx_idx_r    <= tx_idx_nxt;
      tx_crc_r    <= tx_crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      kind_r    <= in_kind;
      rx_byte_r <= in_rx_byte;
    end
    out_kind_r       <= out_kind_nxt;
    out_tx_byte_r    <= out_tx_byte_nxt;
    out_last_r       <= out_last_nxt;
    out_status_r     <= out_status_nxt;
    out_read_value_r <= out_read_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_tx_byte    = out_tx_byte_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;

  `ASSERT_CLK(a_last_ends_request, clk, rst_n, (tx_load && tx_idx_r == mbrm_pkg::TX_LAST_IDX) |=> (!tx_busy_r && out_valid_r && out_last_r))
  `ASSERT_CLK(a_completion_goes_idle, clk, rst_n, cmp_load |=> (phase_r == mbrm_pkg::PH_IDLE && rx_count_r == 3'd0 && out_kind_r == mbrm_pkg::OUT_COMPLETE))
  `ASSERT_NEVER(a_rx_count_range, clk, rst_n, rx_count_r > mbrm_pkg::RX_CRC_HI_IDX)
  `ASSERT_NEVER(a_no_item_during_request, clk, rst_n, proc_go && tx_busy_r)

endmodule
